>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the compositing unit checkers
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, cons may start with a constant delay
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/pcu_pkg.sv
// ---------------------------------------------------------------------------
// pcu_pkg
// types, codes and helpers of the pixel compositing unit
// ---------------------------------------------------------------------------
package pcu_pkg;

  localparam int CHAN_W   = 8;
  localparam int WEIGHT_W = 9;
  localparam int WRAW_W   = 16;
  localparam int PROD_W   = 18;
  localparam int CFG_W    = 32;
  localparam int IDX_W    = 2;

  localparam logic [2:0] MODE_COPY        = 3'd0;
  localparam logic [2:0] MODE_KEY         = 3'd1;
  localparam logic [2:0] MODE_TEST        = 3'd2;
  localparam logic [2:0] MODE_SRC_ALPHA   = 3'd3;
  localparam logic [2:0] MODE_CONST_ALPHA = 3'd4;

  localparam logic [IDX_W-1:0] REG_MODE      = 2'd0;
  localparam logic [IDX_W-1:0] REG_COLOR_KEY = 2'd1;
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd2;
  localparam logic [IDX_W-1:0] REG_WEIGHT    = 2'd3;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

  typedef struct packed {
    logic [CHAN_W-1:0] src_red;
    logic [CHAN_W-1:0] src_green;
    logic [CHAN_W-1:0] src_blue;
    logic [CHAN_W-1:0] src_alpha;
    logic [CHAN_W-1:0] dst_red;
    logic [CHAN_W-1:0] dst_green;
    logic [CHAN_W-1:0] dst_blue;
    logic [CHAN_W-1:0] dst_alpha;
  } pixel_in_t;

  typedef struct packed {
    logic              write_enable;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
  } pixel_out_t;

  typedef struct packed {
    logic write;
    logic blend;
  } ctl_t;

  typedef struct packed {
    ctl_t              ctl;
    logic              is_src;
    logic [WRAW_W-1:0] wraw;
  } front_t;

  typedef struct packed {
    logic load_mul;
    logic load_out;
  } lane_en_t;

  // floor(p / 255) for p below 65535
  function automatic logic [WEIGHT_W-1:0] div255(input logic [WRAW_W-1:0] p);
    logic [WRAW_W:0] t;
    t = {1'b0, p} + 17'd1 + {9'd0, p[WRAW_W-1:8]};
    return t[WRAW_W:8];
  endfunction

endpackage

>>> hw/rtl/pcu_stream_if.sv
// ---------------------------------------------------------------------------
// pcu_stream_if
// valid/ready stream carrying one word of a given payload type
// ---------------------------------------------------------------------------
interface pcu_stream_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/pixel_composite_unit.sv
// ---------------------------------------------------------------------------
// pixel_composite_unit
// per-pixel copy, color key, alpha test and alpha blend over four lanes
// ---------------------------------------------------------------------------
//  channel   dir  word                        handshake
//  pix_in    in   source and destination pix  valid/ready
//  pix_out   out  write enable and pixel      valid/ready
//  cfg       in   register index and data     write enable only
//
//  one pixel per clock while the output is not stalled
//  stages: weight product, lane multiplier, lane add and clamp
//  reset clears the stage valids and the configuration registers
//  a stalled result holds; earlier stages keep filling until all are full
// ---------------------------------------------------------------------------
module pixel_composite_unit import pcu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  pcu_stream_if.sink       pix_in,
  pcu_stream_if.source     pix_out,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  pixel_in_t           px;
  pixel_in_t           px1;
  front_t              front1;
  ctl_t                ctl2;
  logic                we3;
  logic [WEIGHT_W-1:0] w1;
  lane_en_t            lane_en;
  logic [CHAN_W-1:0]   r_red, r_green, r_blue, r_alpha;

  assign rdy3 = !v3 || pix_out.ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign pix_in.ready = rdy1;
  assign px           = pix_in.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= pix_in.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  pcu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .load      (rdy1 && pix_in.valid),
    .px        (px),
    .px_q      (px1),
    .front_q   (front1)
  );

  assign w1 = front1.is_src ? div255(front1.wraw) : front1.wraw[WEIGHT_W-1:0];

  assign lane_en.load_mul = rdy2 && v1;
  assign lane_en.load_out = rdy3 && v2;

  always_ff @(posedge clk) begin
    if (lane_en.load_mul) ctl2 <= front1.ctl;
    if (lane_en.load_out) we3  <= ctl2.write;
  end

  pcu_lane u_lane_red (
    .clk (clk), .en (lane_en), .w (w1), .src (px1.src_red), .dst (px1.dst_red),
    .ctl2 (ctl2), .res (r_red)
  );
  pcu_lane u_lane_green (
    .clk (clk), .en (lane_en), .w (w1), .src (px1.src_green), .dst (px1.dst_green),
    .ctl2 (ctl2), .res (r_green)
  );
  pcu_lane u_lane_blue (
    .clk (clk), .en (lane_en), .w (w1), .src (px1.src_blue), .dst (px1.dst_blue),
    .ctl2 (ctl2), .res (r_blue)
  );
  pcu_lane u_lane_alpha (
    .clk (clk), .en (lane_en), .w (w1), .src (px1.src_alpha), .dst (px1.dst_alpha),
    .ctl2 (ctl2), .res (r_alpha)
  );

  // merge lanes into the result word
  assign pix_out.valid             = v3;
  assign pix_out.data.write_enable = we3;
  assign pix_out.data.out_red      = r_red;
  assign pix_out.data.out_green    = r_green;
  assign pix_out.data.out_blue     = r_blue;
  assign pix_out.data.out_alpha    = r_alpha;

endmodule

>>> hw/rtl/pcu_front.sv
// ---------------------------------------------------------------------------
// pcu_front
// configuration registers, mode decode and source alpha weight product
// ---------------------------------------------------------------------------
module pcu_front import pcu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             load,
  input  pixel_in_t        px,
  output pixel_in_t        px_q,
  output front_t           front_q
);

  logic [2:0]          mode;
  logic [CFG_W-1:0]    color_key;
  logic [CHAN_W-1:0]   alpha_threshold;
  logic [WEIGHT_W-1:0] alpha_weight;

  logic [WEIGHT_W-1:0] sat_w;
  logic [WRAW_W:0]     mul_full;
  logic [CFG_W-1:0]    packed_src;
  front_t              front_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_COPY;
      color_key       <= '0;
      alpha_threshold <= '0;
      alpha_weight    <= WEIGHT_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:      mode            <= cfg_data[2:0];
        REG_COLOR_KEY: color_key       <= cfg_data;
        REG_THRESHOLD: alpha_threshold <= cfg_data[CHAN_W-1:0];
        REG_WEIGHT:    alpha_weight    <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign sat_w      = (alpha_weight > WEIGHT_ONE) ? WEIGHT_ONE : alpha_weight;
  assign packed_src = {px.src_red, px.src_green, px.src_blue, px.src_alpha};
  assign mul_full   = {9'd0, px.src_alpha} * {8'd0, sat_w};

  always_comb begin
    front_next.ctl.write = 1'b1;
    front_next.ctl.blend = 1'b0;
    front_next.is_src    = 1'b0;
    front_next.wraw      = {7'd0, WEIGHT_ONE};
    case (mode)
      MODE_KEY: begin
        front_next.ctl.write = (packed_src != color_key);
      end
      MODE_TEST: begin
        front_next.ctl.write = (px.src_alpha > alpha_threshold);
      end
      MODE_SRC_ALPHA: begin
        front_next.ctl.blend = 1'b1;
        front_next.is_src    = 1'b1;
        front_next.wraw      = mul_full[WRAW_W-1:0];
      end
      MODE_CONST_ALPHA: begin
        front_next.ctl.blend = 1'b1;
        front_next.wraw      = {7'd0, sat_w};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px_q    <= px;
      front_q <= front_next;
    end
  end

endmodule

>>> hw/rtl/pcu_lane.sv
// ---------------------------------------------------------------------------
// pcu_lane
// one color channel: scaled difference, then add, clamp and select
// ---------------------------------------------------------------------------
module pcu_lane import pcu_pkg::*; (
  input  logic                clk,
  input  lane_en_t            en,
  input  logic [WEIGHT_W-1:0] w,
  input  logic [CHAN_W-1:0]   src,
  input  logic [CHAN_W-1:0]   dst,
  input  ctl_t                ctl2,
  output logic [CHAN_W-1:0]   res
);

  logic signed [PROD_W:0]   diff_ext;
  logic signed [PROD_W:0]   w_ext;
  logic signed [PROD_W:0]   prod_full;
  logic signed [PROD_W-1:0] prod;
  logic [CHAN_W-1:0]        src2;
  logic [CHAN_W-1:0]        dst2;

  logic signed [PROD_W-1:0] step_full;
  logic signed [10:0]       sum;
  logic [CHAN_W-1:0]        mixed;
  logic [CHAN_W-1:0]        res_next;

  assign diff_ext  = $signed({11'd0, src}) - $signed({11'd0, dst});
  assign w_ext     = $signed({10'd0, w});
  assign prod_full = diff_ext * w_ext;

  always_ff @(posedge clk) begin
    if (en.load_mul) begin
      prod <= prod_full[PROD_W-1:0];
      src2 <= src;
      dst2 <= dst;
    end
  end

  assign step_full = prod >>> 8;
  assign sum       = $signed({3'd0, dst2}) + step_full[10:0];

  always_comb begin
    if (sum < 0) begin
      mixed = '0;
    end else if (sum > 11'sd255) begin
      mixed = '1;
    end else begin
      mixed = sum[CHAN_W-1:0];
    end
    if (!ctl2.write) begin
      res_next = dst2;
    end else if (ctl2.blend) begin
      res_next = mixed;
    end else begin
      res_next = src2;
    end
  end

  always_ff @(posedge clk) begin
    if (en.load_out) begin
      res <= res_next;
    end
  end

endmodule

>>> hw/rtl/pcu_checker.sv
// ---------------------------------------------------------------------------
// pcu_checker
// port-level checks of the compositing unit, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pcu_checker import pcu_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input pixel_out_t out_data
);

  `ASSERT_IMPL(a_reset_empty, clk, rst, $past(rst), !out_valid)
  `ASSERT_IMPL(a_latency, clk, rst, in_valid && in_ready, ##3 out_valid)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_data_hold, clk, rst, out_valid && !out_ready, $stable(out_data))

endmodule

bind pixel_composite_unit pcu_checker u_pcu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .out_data  (pix_out.data)
);

>>> tb/sv/pixel_composite_unit_tb.sv
// ---------------------------------------------------------------------------
// pixel_composite_unit_tb
// Streams source/destination pixel pairs through the compositing unit under
// copy, color key, alpha test and both blend modes. Each result word is
// checked against a local fixed point predictor, with random gaps on both
// sides, a long output hold-off and a final drain.
// ---------------------------------------------------------------------------
module pixel_composite_unit_tb import pcu_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 7;
  localparam int TAIL_CYCLES  = 12;
  localparam int MAX_PRINTED  = 20;
  localparam int PHASES       = 16;
  localparam int PHASE_ITEMS  = 95;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  pcu_stream_if #(.data_t(pixel_in_t))  pix_in ();
  pcu_stream_if #(.data_t(pixel_out_t)) pix_out ();

  pixel_composite_unit dut (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in),
    .pix_out   (pix_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  logic [2:0]          mode_q      = MODE_COPY;
  logic [31:0]         key_q       = '0;
  logic [CHAN_W-1:0]   threshold_q = '0;
  logic [WEIGHT_W-1:0] weight_q    = WEIGHT_ONE;

  pixel_out_t  expected_pixels[$];
  int unsigned error_count = 0;
  bit          steady      = 1'b0;
  int unsigned hold_cycles = 0;

  function automatic logic [CHAN_W-1:0] lerp_channel(input logic [CHAN_W-1:0] d,
                                                     input logic [CHAN_W-1:0] s,
                                                     input int w);
    int scaled;
    int r;
    scaled = (int'(s) - int'(d)) * w;
    r = int'(d) + (scaled >>> 8);
    if (r < 0) r = 0;
    else if (r > 255) r = 255;
    return CHAN_W'(r);
  endfunction

  function automatic pixel_out_t composite_pixel(input pixel_in_t px);
    logic [CHAN_W-1:0] src [4];
    logic [CHAN_W-1:0] dst [4];
    logic [CHAN_W-1:0] res [4];
    logic              wr;
    logic              mix;
    int                sat;
    int                w;
    pixel_out_t        result;
    src = '{px.src_red, px.src_green, px.src_blue, px.src_alpha};
    dst = '{px.dst_red, px.dst_green, px.dst_blue, px.dst_alpha};
    wr  = 1'b1;
    mix = 1'b0;
    sat = (weight_q > WEIGHT_ONE) ? int'(WEIGHT_ONE) : int'(weight_q);
    w   = sat;
    case (mode_q)
      MODE_KEY:  wr = ({px.src_red, px.src_green, px.src_blue, px.src_alpha} != key_q);
      MODE_TEST: wr = (px.src_alpha > threshold_q);
      MODE_SRC_ALPHA: begin
        mix = 1'b1;
        w   = (int'(px.src_alpha) * sat) / 255;
      end
      MODE_CONST_ALPHA: mix = 1'b1;
      default: ;
    endcase
    for (int i = 0; i < 4; i++) begin
      if (!wr) res[i] = dst[i];
      else if (mix) res[i] = lerp_channel(dst[i], src[i], w);
      else res[i] = src[i];
    end
    result.write_enable = wr;
    result.out_red      = res[0];
    result.out_green    = res[1];
    result.out_blue     = res[2];
    result.out_alpha    = res[3];
    return result;
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, what);
    error_count++;
  endtask

  task automatic compare_field(input string field, input logic [CHAN_W-1:0] got,
                               input logic [CHAN_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
  endtask

  task automatic check_pixel(input pixel_out_t got);
    pixel_out_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch($sformatf("word %h with nothing pending", got));
      return;
    end
    want = expected_pixels.pop_front();
    compare_field("write_enable", CHAN_W'(got.write_enable), CHAN_W'(want.write_enable));
    compare_field("out_red", got.out_red, want.out_red);
    compare_field("out_green", got.out_green, want.out_green);
    compare_field("out_blue", got.out_blue, want.out_blue);
    compare_field("out_alpha", got.out_alpha, want.out_alpha);
  endtask

  task automatic send_pixel(input pixel_in_t px);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.data  <= px;
    do @(posedge clk); while (pix_in.ready !== 1'b1);
    expected_pixels.push_back(composite_pixel(px));
  endtask

  task automatic wait_drained();
    pix_in.valid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE:      mode_q      = value[2:0];
      REG_COLOR_KEY: key_q       = value;
      REG_THRESHOLD: threshold_q = value[CHAN_W-1:0];
      REG_WEIGHT:    weight_q    = value[WEIGHT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // upper data bits are junk, only the register width counts
  task automatic configure(input logic [2:0] m, input logic [31:0] key,
                           input logic [CHAN_W-1:0] thr, input logic [WEIGHT_W-1:0] wt);
    write_register(REG_MODE, {29'($urandom), m});
    write_register(REG_COLOR_KEY, key);
    write_register(REG_THRESHOLD, {24'($urandom), thr});
    write_register(REG_WEIGHT, {23'($urandom), wt});
  endtask

  function automatic logic [CHAN_W-1:0] random_channel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic pixel_in_t phase_pixel();
    pixel_in_t px;
    px = {random_channel(), random_channel(), random_channel(), random_channel(),
          random_channel(), random_channel(), random_channel(), random_channel()};
    case (mode_q)
      MODE_KEY: begin
        case ($urandom_range(0, 2))
          0: {px.src_red, px.src_green, px.src_blue, px.src_alpha} = key_q;
          1: {px.src_red, px.src_green, px.src_blue, px.src_alpha} =
               key_q ^ (32'd1 << $urandom_range(0, 31));
          default: ;
        endcase
      end
      MODE_TEST: begin
        if ($urandom_range(0, 1) == 1)
          px.src_alpha = CHAN_W'(int'(threshold_q) + int'($urandom_range(0, 2)) - 1);
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic random_configure();
    logic [2:0]          m;
    logic [31:0]         key;
    logic [CHAN_W-1:0]   thr;
    logic [WEIGHT_W-1:0] wt;
    if ($urandom_range(0, 9) == 0) m = 3'($urandom_range(int'(MODE_CONST_ALPHA) + 1, 7));
    else m = 3'($urandom_range(int'(MODE_COPY), int'(MODE_CONST_ALPHA)));
    case ($urandom_range(0, 3))
      0:       key = '0;
      1:       key = '1;
      default: key = $urandom;
    endcase
    case ($urandom_range(0, 3))
      0:       thr = '0;
      1:       thr = '1;
      default: thr = CHAN_W'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       wt = '0;
      1:       wt = WEIGHT_ONE;
      2:       wt = WEIGHT_W'($urandom_range(int'(WEIGHT_ONE) + 1, 511));
      3:       wt = '1;
      default: wt = WEIGHT_W'($urandom_range(0, int'(WEIGHT_ONE)));
    endcase
    configure(m, key, thr, wt);
  endtask

  task automatic test_reset_values();
    send_pixel(pixel_in_t'({32'h0c22_384e, 32'hf0e0_d0c0}));
    wait_drained();
    write_register(REG_MODE, CFG_W'(MODE_CONST_ALPHA));
    send_pixel(pixel_in_t'({32'h1020_3040, 32'hc0d0_e0f0}));
    wait_drained();
    write_register(REG_MODE, CFG_W'(MODE_KEY));
    send_pixel(pixel_in_t'({32'h0000_0000, 32'h1122_3344}));
    wait_drained();
    write_register(REG_MODE, CFG_W'(MODE_TEST));
    send_pixel(pixel_in_t'({32'h8899_aa00, 32'h5566_7788}));
    wait_drained();
  endtask

  task automatic test_copy_modes();
    configure(MODE_COPY, $urandom, CHAN_W'($urandom), WEIGHT_W'($urandom));
    send_pixel(pixel_in_t'({32'h0000_0000, 32'hffff_ffff}));
    send_pixel(pixel_in_t'({32'hffff_ffff, 32'h0000_0000}));
    send_pixel(pixel_in_t'({32'h55aa_55aa, 32'haa55_aa55}));
    for (int k = int'(MODE_CONST_ALPHA) + 1; k <= 7; k++) begin
      wait_drained();
      configure(3'(k), $urandom, CHAN_W'($urandom), WEIGHT_W'($urandom));
      send_pixel(pixel_in_t'({32'h3c5a_7896, 32'hc3a5_8769}));
    end
    wait_drained();
  endtask

  task automatic test_color_key();
    configure(MODE_KEY, 32'h1234_5678, '0, WEIGHT_ONE);
    send_pixel(pixel_in_t'({32'h1234_5678, 32'h9abc_def0}));
    send_pixel(pixel_in_t'({32'h1334_5678, 32'h9abc_def0}));
    send_pixel(pixel_in_t'({32'h1235_5678, 32'h9abc_def0}));
    send_pixel(pixel_in_t'({32'h1234_5778, 32'h9abc_def0}));
    send_pixel(pixel_in_t'({32'h1234_5679, 32'h9abc_def0}));
    wait_drained();
  endtask

  task automatic test_alpha_test();
    configure(MODE_TEST, $urandom, 8'h80, WEIGHT_ONE);
    send_pixel(pixel_in_t'({32'hffee_dd80, 32'h0102_0304}));
    send_pixel(pixel_in_t'({32'hffee_dd81, 32'h0102_0304}));
    wait_drained();
    configure(MODE_TEST, $urandom, '1, WEIGHT_ONE);
    send_pixel(pixel_in_t'({32'hffff_ffff, 32'h0000_0000}));
    wait_drained();
  endtask

  task automatic test_blend();
    configure(MODE_SRC_ALPHA, '0, '0, WEIGHT_ONE);
    send_pixel(pixel_in_t'({32'hffff_ffff, 32'h0000_0000}));
    send_pixel(pixel_in_t'({32'hffff_ff00, 32'h1020_3040}));
    send_pixel(pixel_in_t'({32'h0000_0080, 32'hffff_ffff}));
    wait_drained();
    configure(MODE_SRC_ALPHA, '0, '0, '1);
    send_pixel(pixel_in_t'({32'h4080_c0c8, 32'hc080_4010}));
    wait_drained();
    configure(MODE_CONST_ALPHA, '0, '0, '0);
    send_pixel(pixel_in_t'({32'hffff_ffff, 32'h1234_5678}));
    wait_drained();
    configure(MODE_CONST_ALPHA, '0, '0, 9'd1);
    send_pixel(pixel_in_t'({32'h0000_0000, 32'hffff_ffff}));
    wait_drained();
    configure(MODE_CONST_ALPHA, '0, '0, '1);
    send_pixel(pixel_in_t'({32'h0102_0304, 32'hfefd_fcfb}));
    wait_drained();
  endtask

  task automatic test_backpressure();
    random_configure();
    steady      = 1'b1;
    hold_cycles = 40;
    repeat (30) send_pixel(phase_pixel());
    wait_drained();
    repeat (30) send_pixel(phase_pixel());
    wait_drained();
    steady = 1'b0;
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < PHASES; p++) begin
      random_configure();
      steady = (p % 4 == 3);
      repeat (PHASE_ITEMS) send_pixel(phase_pixel());
      wait_drained();
    end
    steady = 1'b0;
  endtask

  initial begin : result_sink
    int unsigned stall;
    pix_out.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 3);
      end
      if (stall > 0) begin
        pix_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pix_out.ready <= 1'b1;
      do @(posedge clk); while (pix_out.valid !== 1'b1);
      check_pixel(pix_out.data);
    end
  end

  initial begin
    #5_000_000;
    $display("pixel_composite_unit_tb NOT OK");
    $finish;
  end

  initial begin
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    pix_in.valid <= 1'b0;
    pix_in.data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_copy_modes();
    test_color_key();
    test_alpha_test();
    test_blend();
    test_backpressure();
    test_random_phases();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("pixel_composite_unit_tb OK");
    end else begin
      $display("pixel_composite_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> pixel_composite_unit.f
+incdir+hw/rtl
hw/rtl/pcu_pkg.sv
hw/rtl/pcu_stream_if.sv
hw/rtl/pcu_front.sv
hw/rtl/pcu_lane.sv
hw/rtl/pixel_composite_unit.sv
hw/rtl/pcu_checker.sv
tb/sv/pixel_composite_unit_tb.sv
